// ===== rtl/tbr_pkg.sv =====
package tbr_pkg;

    localparam int unsigned REQ_W     = 2;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned BITCNT_W  = 4;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SYNC = 2'd1;
    localparam logic [REQ_W-1:0] REQ_NEXT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_DELAY = 2'd1;

    localparam logic [BYTE_W-1:0]   SYNC_BYTE_RESET  = 8'd230;
    localparam logic [BYTE_W-1:0]   READ_DELAY_RESET = 8'd75;
    localparam logic [BITCNT_W-1:0] BITS_PER_BYTE    = 4'd8;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_EDGE  = 2'd1,
        PH_DELAY = 2'd2
    } phase_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             tape_level;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              inverted;
    } result_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_byte;
        logic [BYTE_W-1:0] read_delay;
    } cfg_t;

endpackage

// ===== rtl/tbr_ifs.sv =====
interface tbr_item_if;
    logic                      valid;
    logic                      ready;
    logic [tbr_pkg::REQ_W-1:0] req_type;
    logic                      tape_level;

    modport source (output valid, output req_type, output tape_level, input ready);
    modport sink   (input valid, input req_type, input tape_level, output ready);
endinterface

interface tbr_result_if;
    logic                       valid;
    logic                       ready;
    logic [tbr_pkg::BYTE_W-1:0] data_byte;
    logic                       inverted;

    modport source (output valid, output data_byte, output inverted, input ready);
    modport sink   (input valid, input data_byte, input inverted, output ready);
endinterface

interface tbr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tbr_pkg::CFG_IDX_W-1:0] index;
    logic [tbr_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tbr_cfg_regs.sv =====
module tbr_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    tbr_cfg_if.sink       cfg,
    output tbr_pkg::cfg_t cfg_vals
);
    import tbr_pkg::*;

    logic [BYTE_W-1:0] sync_byte_reg;
    logic [BYTE_W-1:0] read_delay_reg;

    assign cfg.ready = 1'b1;

    // writes to unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg  <= SYNC_BYTE_RESET;
            read_delay_reg <= READ_DELAY_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_SYNC_BYTE)
                sync_byte_reg <= cfg.data;
            if (cfg.index == CFG_READ_DELAY)
                read_delay_reg <= cfg.data;
        end
    end

    assign cfg_vals.sync_byte  = sync_byte_reg;
    assign cfg_vals.read_delay = read_delay_reg;

endmodule

// ===== rtl/tbr_in_stage.sv =====
module tbr_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    tbr_item_if.sink       item,
    input  logic           take,
    output logic           held,
    output tbr_pkg::item_t held_item
);
    import tbr_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign item.ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (item.ready)
            valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            item_reg.req_type   <= item.req_type;
            item_reg.tape_level <= item.tape_level;
        end
    end

    assign held      = valid_reg;
    assign held_item = item_reg;

endmodule

// ===== rtl/tbr_core.sv =====
module tbr_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  tbr_pkg::item_t   cur,
    input  tbr_pkg::cfg_t    cfg_vals,
    output logic             emit,
    output tbr_pkg::result_t res
);
    import tbr_pkg::*;

    phase_t              phase_reg,      phase_next;
    logic [BYTE_W-1:0]   shift_reg,      shift_next;
    logic                ref_level_reg,  ref_level_next;
    logic [BYTE_W-1:0]   delay_reg,      delay_next;
    logic [BITCNT_W-1:0] bits_reg,       bits_next;
    logic                searching_reg,  searching_next;
    logic                polarity_reg,   polarity_next;
    logic [BYTE_W-1:0]   delay_dec;
    logic [BITCNT_W-1:0] bits_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            shift_reg     <= '0;
            ref_level_reg <= 1'b0;
            delay_reg     <= '0;
            bits_reg      <= '0;
            searching_reg <= 1'b0;
            polarity_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            shift_reg     <= shift_next;
            ref_level_reg <= ref_level_next;
            delay_reg     <= delay_next;
            bits_reg      <= bits_next;
            searching_reg <= searching_next;
            polarity_reg  <= polarity_next;
        end
    end

    assign delay_dec = delay_reg - 1'b1;
    assign bits_dec  = bits_reg - 1'b1;

    always_comb
    begin
        phase_next     = phase_reg;
        shift_next     = shift_reg;
        ref_level_next = ref_level_reg;
        delay_next     = delay_reg;
        bits_next      = bits_reg;
        searching_next = searching_reg;
        polarity_next  = polarity_reg;
        emit           = 1'b0;

        if (cur.req_type inside {REQ_SYNC, REQ_NEXT})
        begin
            // restart the read, even mid-byte
            shift_next     = '0;
            ref_level_next = cur.tape_level;
            searching_next = (cur.req_type == REQ_SYNC);
            bits_next      = BITS_PER_BYTE;
            delay_next     = '0;
            phase_next     = PH_EDGE;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_EDGE:
                begin
                    if (cur.tape_level != ref_level_reg)
                    begin
                        shift_next = {shift_reg[BYTE_W-2:0], cur.tape_level};
                        delay_next = cfg_vals.read_delay;
                        phase_next = PH_DELAY;
                    end
                end
                PH_DELAY:
                begin
                    delay_next = delay_dec;
                    if (delay_dec == '0)
                    begin
                        ref_level_next = cur.tape_level;
                        phase_next     = PH_EDGE;
                        if (searching_reg)
                        begin
                            if (shift_reg == cfg_vals.sync_byte)
                            begin
                                polarity_next  = 1'b0;
                                searching_next = 1'b0;
                                bits_next      = BITS_PER_BYTE;
                            end
                            else if (shift_reg == ~cfg_vals.sync_byte)
                            begin
                                polarity_next  = 1'b1;
                                searching_next = 1'b0;
                                bits_next      = BITS_PER_BYTE;
                            end
                        end
                        else
                        begin
                            bits_next = bits_dec;
                            if (bits_dec == '0)
                            begin
                                phase_next = PH_IDLE;
                                emit       = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    assign res.data_byte = shift_reg ^ {BYTE_W{polarity_reg}};
    assign res.inverted  = polarity_reg;

endmodule

// ===== rtl/tbr_out_stage.sv =====
module tbr_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  tbr_pkg::result_t res,
    output logic             free,
    tbr_result_if.source     result
);
    import tbr_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign free = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (result.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign result.valid     = valid_reg;
    assign result.data_byte = res_reg.data_byte;
    assign result.inverted  = res_reg.inverted;

endmodule

// ===== rtl/biphase_tape_byte_receiver.sv =====
// Channel   Role    Payload
// item      sink    req_type, tape_level (one tick sample or start request)
// result    source  data_byte, inverted (one per completed byte)
// cfg       sink    index, data (0 sync byte, 1 read delay; always ready)
//
// One request a cycle unless a completed byte waits: a request is registered,
// and the decoder state and result register are then updated from it as it leaves the input register.
// Reset clears the decoder to idle and loads sync byte 230, read delay 75.
// A request that completes a byte waits in the input register only while a
// previous byte is still held in the result register; all others proceed.
module biphase_tape_byte_receiver (
    input  logic         clk,
    input  logic         rst_n,
    tbr_item_if.sink     item,
    tbr_result_if.source result,
    tbr_cfg_if.sink      cfg
);
    import tbr_pkg::*;

    cfg_t    cfg_vals;
    item_t   cur;
    result_t res;
    logic    held;
    logic    emit;
    logic    out_free;
    logic    step;

    // advance unless a byte would overwrite one not yet taken
    assign step = held && (!emit || out_free);

    tbr_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_vals (cfg_vals)
    );

    tbr_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .take      (step),
        .held      (held),
        .held_item (cur)
    );

    tbr_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .cur      (cur),
        .cfg_vals (cfg_vals),
        .emit     (emit),
        .res      (res)
    );

    tbr_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (step && emit),
        .res    (res),
        .free   (out_free),
        .result (result)
    );

endmodule

// ===== bench/biphase_tape_byte_receiver_test.sv =====
module biphase_tape_byte_receiver_test;
    import tbr_pkg::*;

    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
    localparam int ITEM_TARGET = 1500;
    localparam int BYTE_TARGET = 40;
    localparam int PHASE_ITEMS = 250;
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES = 8;
    localparam int LIMIT_CYCLES = 1000000;

    typedef enum int {
        PACE_FREE,
        PACE_SENDER,
        PACE_RECEIVER,
        PACE_BOTH
    } pace_t;

    // result pinned by the directed script, carried alongside each request
    typedef struct packed {
        bit      pinned;
        result_t value;
    } pinned_t;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic              lvl;
        bit                pinned;
        logic [BYTE_W-1:0] data;
        logic              inv;
    } step_t;

    localparam pinned_t NO_PIN = '0;

    logic clk;
    logic rst_n;

    tbr_item_if   item_ch ();
    tbr_result_if result_ch ();
    tbr_cfg_if    cfg_ch ();

    biphase_tape_byte_receiver dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // decoder mirror
    phase_t             dec_phase;
    logic [BYTE_W-1:0]  dec_shift;
    logic               dec_ref;
    logic [BYTE_W-1:0]  dec_wait;
    logic [BITCNT_W-1:0] dec_bits;
    logic               dec_hunting;
    logic               dec_invert;
    logic [BYTE_W-1:0]  sync_pat;
    logic [BYTE_W-1:0]  delay_ticks;

    result_t byte_queue[$];
    pinned_t pin_r;

    // stimulus side copy of the settings
    logic [BYTE_W-1:0] gen_sync;
    logic [BYTE_W-1:0] gen_delay;

    int unsigned gap_pct;
    int unsigned stall_pct;
    int errors;
    int cycles;
    int active_items;
    int bytes_seen;
    int syncs_normal;
    int syncs_inverted;

    result_t made;
    result_t want;
    bit      got;

    step_t script [23] = '{
        '{REQ_TICK,  1'b1, 1'b0, 8'h00, 1'b0},
        '{REQ_SPARE, 1'b0, 1'b0, 8'h00, 1'b0},
        '{REQ_SYNC,  1'b0, 1'b0, 8'h00, 1'b0},
        '{REQ_TICK,  1'b1, 1'b0, 8'h00, 1'b0},
        '{REQ_NEXT,  1'b1, 1'b0, 8'h00, 1'b0},
        '{REQ_NEXT,  1'b0, 1'b0, 8'h00, 1'b0},
        '{REQ_TICK,  1'b1, 1'b0, 8'h00, 1'b0},
        '{REQ_TICK,  1'b0, 1'b0, 8'h00, 1'b0},
        '{REQ_TICK,  1'b1, 1'b0, 8'h00, 1'b0},
        '{REQ_SPARE, 1'b0, 1'b0, 8'h00, 1'b0},
        '{REQ_SPARE, 1'b1, 1'b0, 8'h00, 1'b0},
        '{REQ_TICK,  1'b0, 1'b0, 8'h00, 1'b0},
        '{REQ_TICK,  1'b1, 1'b0, 8'h00, 1'b0},
        '{REQ_TICK,  1'b0, 1'b0, 8'h00, 1'b0},
        '{REQ_TICK,  1'b1, 1'b0, 8'h00, 1'b0},
        '{REQ_SPARE, 1'b0, 1'b0, 8'h00, 1'b0},
        '{REQ_TICK,  1'b1, 1'b0, 8'h00, 1'b0},
        '{REQ_TICK,  1'b0, 1'b0, 8'h00, 1'b0},
        '{REQ_TICK,  1'b1, 1'b0, 8'h00, 1'b0},
        '{REQ_TICK,  1'b0, 1'b0, 8'h00, 1'b0},
        '{REQ_SPARE, 1'b1, 1'b0, 8'h00, 1'b0},
        '{REQ_TICK,  1'b0, 1'b1, 8'hFF, 1'b0},
        '{REQ_TICK,  1'b1, 1'b0, 8'h00, 1'b0}
    };

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic bit decode_request(input logic [REQ_W-1:0] req, input logic lvl,
                                          output result_t res);
        bit done;
        done = 1'b0;
        res = '0;
        if (req == REQ_SYNC || req == REQ_NEXT)
        begin
            dec_shift = '0;
            dec_ref = lvl;
            dec_hunting = (req == REQ_SYNC);
            dec_bits = BITS_PER_BYTE;
            dec_wait = '0;
            dec_phase = PH_EDGE;
        end
        else
        begin
            case (dec_phase)
                PH_EDGE:
                begin
                    if (lvl != dec_ref)
                    begin
                        dec_shift = {dec_shift[BYTE_W-2:0], lvl};
                        dec_wait = delay_ticks;
                        dec_phase = PH_DELAY;
                    end
                end
                PH_DELAY:
                begin
                    // a zero delay wraps round to a full 256 ticks
                    dec_wait = dec_wait - 1'b1;
                    if (dec_wait == 0)
                    begin
                        dec_ref = lvl;
                        dec_phase = PH_EDGE;
                        if (dec_hunting)
                        begin
                            if (dec_shift == sync_pat)
                            begin
                                dec_invert = 1'b0;
                                dec_hunting = 1'b0;
                                dec_bits = BITS_PER_BYTE;
                                syncs_normal++;
                            end
                            else if (dec_shift == ~sync_pat)
                            begin
                                dec_invert = 1'b1;
                                dec_hunting = 1'b0;
                                dec_bits = BITS_PER_BYTE;
                                syncs_inverted++;
                            end
                        end
                        else
                        begin
                            dec_bits = dec_bits - 1'b1;
                            if (dec_bits == 0)
                            begin
                                dec_phase = PH_IDLE;
                                res.data_byte = dec_shift ^ {BYTE_W{dec_invert}};
                                res.inverted = dec_invert;
                                done = 1'b1;
                            end
                        end
                    end
                end
                default: dec_phase = PH_IDLE;
            endcase
        end
        return done;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 50)
            $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d bytes still due", cycles, byte_queue.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // check results, then advance the mirror on each accepted request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (byte_queue.size() == 0)
                    report_mismatch($sformatf("unexpected byte %02h inverted %0b",
                                              result_ch.data_byte, result_ch.inverted));
                else
                begin
                    want = byte_queue.pop_front();
                    bytes_seen++;
                    if (result_ch.data_byte !== want.data_byte)
                        report_mismatch($sformatf("data_byte %02h, expected %02h",
                                                  result_ch.data_byte, want.data_byte));
                    if (result_ch.inverted !== want.inverted)
                        report_mismatch($sformatf("inverted %0b, expected %0b",
                                                  result_ch.inverted, want.inverted));
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                if (item_ch.req_type == REQ_SYNC || item_ch.req_type == REQ_NEXT
                    || dec_phase != PH_IDLE)
                    active_items++;
                got = decode_request(item_ch.req_type, item_ch.tape_level, made);
                if (pin_r.pinned)
                    byte_queue.push_back(pin_r.value);
                else if (got)
                    byte_queue.push_back(made);
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    CFG_SYNC_BYTE:  sync_pat = cfg_ch.data;
                    CFG_READ_DELAY: delay_ticks = cfg_ch.data;
                    default: ;
                endcase
            end
        end
    end

    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_SENDER:   begin gap_pct = 83; stall_pct = 0;  end
            PACE_RECEIVER: begin gap_pct = 0;  stall_pct = 83; end
            PACE_BOTH:     begin gap_pct = 10; stall_pct = 10; end
            default:       begin gap_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    task automatic drive(input logic [REQ_W-1:0] req, input logic lvl, input pinned_t pin);
        while ($urandom_range(99) < gap_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.req_type <= req;
        item_ch.tape_level <= lvl;
        pin_r <= pin;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    task automatic put_req(input logic [REQ_W-1:0] req, input logic lvl);
        drive(req, lvl, NO_PIN);
    endtask

    function automatic logic [REQ_W-1:0] tick_code();
        return ($urandom_range(7) == 0) ? REQ_SPARE : REQ_TICK;
    endfunction

    // hold until nothing is due, then let the pipeline empty
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (byte_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_SYNC_BYTE)
            gen_sync = val;
        else
            gen_delay = val;
    endtask

    // one encoded bit: the reference is always the complement of the bit,
    // the level at the end of the delay sets up the following bit
    task automatic put_bit(input logic b, input logic after);
        int span;
        span = (gen_delay == 0) ? 256 : gen_delay;
        repeat ($urandom_range(2)) put_req(tick_code(), ~b);
        put_req(tick_code(), b);
        repeat (span - 1) put_req(tick_code(), logic'($urandom_range(1)));
        put_req(tick_code(), after);
    endtask

    task automatic send_stream(input logic [REQ_W-1:0] start, input bit bits_q[$]);
        logic after;
        put_req(start, ~bits_q[0]);
        for (int i = 0; i < bits_q.size(); i++)
        begin
            after = (i + 1 < bits_q.size()) ? ~bits_q[i+1] : logic'($urandom_range(1));
            put_bit(bits_q[i], after);
        end
    endtask

    task automatic push_byte(ref bit bits_q[$], input logic [BYTE_W-1:0] v);
        for (int i = BYTE_W - 1; i >= 0; i--)
            bits_q.push_back(v[i]);
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom_range(255));
        endcase
    endfunction

    task automatic cut_short(ref bit bits_q[$]);
        int keep;
        keep = $urandom_range(1, bits_q.size() - 1);
        while (bits_q.size() > keep)
            void'(bits_q.pop_back());
    endtask

    task automatic run_record(input bit broken);
        bit bits_q[$];
        logic [BYTE_W-1:0] pat;
        repeat ($urandom_range(6)) bits_q.push_back(bit'($urandom_range(1)));
        if ($urandom_range(9) == 0)
            pat = BYTE_W'($urandom_range(255));
        else
            pat = $urandom_range(1) ? gen_sync : ~gen_sync;
        push_byte(bits_q, pat);
        push_byte(bits_q, pick_byte());
        if (broken)
            cut_short(bits_q);
        send_stream(REQ_SYNC, bits_q);
    endtask

    task automatic run_next_byte(input bit broken);
        bit bits_q[$];
        push_byte(bits_q, pick_byte());
        if (broken)
            cut_short(bits_q);
        send_stream(REQ_NEXT, bits_q);
    endtask

    // first bit under the given delay, the rest under a short one
    task automatic run_split_byte(input logic [BYTE_W-1:0] first_delay);
        bit bits_q[$];
        logic after;
        push_byte(bits_q, pick_byte());
        write_reg(CFG_READ_DELAY, first_delay);
        put_req(REQ_NEXT, ~bits_q[0]);
        put_bit(bits_q[0], ~bits_q[1]);
        write_reg(CFG_READ_DELAY, 8'd1);
        for (int i = 1; i < BYTE_W; i++)
        begin
            after = (i + 1 < BYTE_W) ? ~bits_q[i+1] : logic'($urandom_range(1));
            put_bit(bits_q[i], after);
        end
    endtask

    initial
    begin
        int pass_no;
        int phase_end;
        int pick;
        pinned_t pin;

        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.req_type = REQ_TICK;
        item_ch.tape_level = 1'b0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_SYNC_BYTE;
        cfg_ch.data = '0;
        pin_r = NO_PIN;
        gap_pct = 0;
        stall_pct = 0;
        errors = 0;
        cycles = 0;
        active_items = 0;
        bytes_seen = 0;
        syncs_normal = 0;
        syncs_inverted = 0;
        dec_phase = PH_IDLE;
        dec_shift = '0;
        dec_ref = 1'b0;
        dec_wait = '0;
        dec_bits = '0;
        dec_hunting = 1'b0;
        dec_invert = 1'b0;
        sync_pat = SYNC_BYTE_RESET;
        delay_ticks = READ_DELAY_RESET;
        gen_sync = SYNC_BYTE_RESET;
        gen_delay = READ_DELAY_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // short delay so the script fits a whole byte; sync stays at reset
        write_reg(CFG_READ_DELAY, 8'd1);
        foreach (script[i])
        begin
            pin.pinned = script[i].pinned;
            pin.value.data_byte = script[i].data;
            pin.value.inverted = script[i].inv;
            drive(script[i].req, script[i].lvl, pin);
        end

        pass_no = 0;
        while (active_items < ITEM_TARGET || bytes_seen < BYTE_TARGET)
        begin
            case (pass_no)
                0: ;
                1:
                begin
                    write_reg(CFG_SYNC_BYTE, 8'h00);
                    write_reg(CFG_READ_DELAY, 8'd2);
                end
                2:
                begin
                    write_reg(CFG_SYNC_BYTE, 8'hFF);
                    write_reg(CFG_READ_DELAY, 8'd1);
                end
                default:
                begin
                    write_reg(CFG_SYNC_BYTE, BYTE_W'($urandom_range(255)));
                    write_reg(CFG_READ_DELAY, BYTE_W'($urandom_range(1, 4)));
                end
            endcase
            set_pace(pace_t'(pass_no % 4));
            phase_end = active_items + PHASE_ITEMS;
            while (active_items < phase_end)
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                    run_record($urandom_range(9) == 0);
                else if (pick < 85)
                    run_next_byte($urandom_range(9) == 0);
                else if (pick < 95)
                    repeat ($urandom_range(1, 12))
                        put_req(REQ_W'($urandom_range(3)), logic'($urandom_range(1)));
                else
                    run_record(1'b1);
            end
            pass_no++;
        end

        // longest and wrapped delays on the first bit of a byte
        set_pace(PACE_BOTH);
        run_split_byte(8'd255);
        set_pace(PACE_FREE);
        run_split_byte(8'd0);

        item_ch.valid <= 1'b0;
        while (byte_queue.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d decoder requests over %0d setting passes, %0d bytes checked",
                 active_items, pass_no, bytes_seen);
        $display("sync found %0d times in normal and %0d times in inverted polarity",
                 syncs_normal, syncs_inverted);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tbr_pkg.sv
rtl/tbr_ifs.sv
rtl/tbr_cfg_regs.sv
rtl/tbr_in_stage.sv
rtl/tbr_core.sv
rtl/tbr_out_stage.sv
rtl/biphase_tape_byte_receiver.sv
bench/biphase_tape_byte_receiver_test.sv
